FILE: design/btps_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Buzzer tone pattern sequencer package
// Shared types, request codes, the tone step ROM and the pattern lengths.
// ----------------------------------------------------------------------------
package btps_pkg;

	// Request codes carried in req_type.
	typedef enum logic [1:0] {
		REQ_TICK = 2'd0,
		REQ_BEEP = 2'd1,
		REQ_MUTE = 2'd2
	} req_code_t;

	// Pattern id that only stops playback.
	localparam logic [2:0] PAT_INVALID = 3'd7;

	localparam logic [4:0] RES_MIN   = 5'd1;
	localparam logic [4:0] RES_MAX   = 5'd16;
	localparam logic [4:0] RES_RESET = 5'd8;

	// Division by 100 is a multiply by ceil(2^30 / 100) and a shift by 30.
	// The volume is folded into the constant, so only one multiply remains.
	localparam int DUTY_RECIP = 10737419;
	localparam int DUTY_SHIFT = 30;

	typedef struct packed {
		logic [9:0]  freq;
		logic [8:0]  dur;
		logic [30:0] scale;  // volume * DUTY_RECIP, zero for a silent step
	} step_t;

	typedef struct packed {
		logic        playing;
		logic        muted;
		logic [2:0]  pattern;
		logic [3:0]  step;
		logic [8:0]  ms_left;
		logic [9:0]  freq;
		logic [15:0] duty;
	} play_state_t;

	function automatic step_t mk_step(input int f, input int d, input int v);
		step_t s;
		s.freq  = 10'(f);
		s.dur   = 9'(d);
		s.scale = 31'(v * DUTY_RECIP);
		return s;
	endfunction

	// Step table indexed by pattern and step within the pattern.
	function automatic step_t step_rom(input logic [2:0] pat, input logic [3:0] idx);
		step_t s;
		s = mk_step(0, 1, 0);
		unique case (pat)
			3'd0: begin
				unique case (idx)
					4'd0: s = mk_step(440, 100, 90);
					4'd1: s = mk_step(0, 80, 0);
					4'd2: s = mk_step(550, 120, 90);
					default: s = mk_step(0, 1, 0);
				endcase
			end
			3'd1: begin
				unique case (idx)
					4'd0: s = mk_step(880, 20, 50);
					4'd1: s = mk_step(880, 400, 100);
					4'd2: s = mk_step(880, 50, 60);
					4'd3: s = mk_step(880, 30, 30);
					default: s = mk_step(0, 1, 0);
				endcase
			end
			3'd2: begin
				unique case (idx)
					4'd0, 4'd3, 4'd6: s = mk_step(800, 100, 100);
					4'd1, 4'd4, 4'd7: s = mk_step(790, 100, 100);
					4'd2, 4'd5:       s = mk_step(0, 100, 0);
					default:          s = mk_step(0, 1, 0);
				endcase
			end
			3'd3: begin
				unique case (idx)
					4'd0: s = mk_step(600, 5, 100);
					4'd1: s = mk_step(500, 25, 90);
					default: s = mk_step(0, 1, 0);
				endcase
			end
			3'd4: begin
				unique case (idx)
					4'd0: s = mk_step(440, 30, 80);
					4'd1: s = mk_step(500, 30, 90);
					4'd2: s = mk_step(580, 30, 100);
					4'd3: s = mk_step(660, 30, 100);
					default: s = mk_step(0, 1, 0);
				endcase
			end
			3'd5: begin
				unique case (idx)
					4'd0: s = mk_step(120, 100, 70);
					4'd1: s = mk_step(0, 50, 0);
					4'd2: s = mk_step(100, 100, 70);
					default: s = mk_step(0, 1, 0);
				endcase
			end
			3'd6: begin
				unique case (idx)
					4'd0: s = mk_step(660, 30, 100);
					4'd1: s = mk_step(580, 30, 100);
					4'd2: s = mk_step(500, 30, 90);
					4'd3: s = mk_step(440, 30, 80);
					default: s = mk_step(0, 1, 0);
				endcase
			end
			default: s = mk_step(0, 1, 0);
		endcase
		return s;
	endfunction

	function automatic logic [3:0] pat_len(input logic [2:0] pat);
		logic [3:0] n;
		unique case (pat)
			3'd0:    n = 4'd4;
			3'd1:    n = 4'd5;
			3'd2:    n = 4'd9;
			3'd3:    n = 4'd3;
			3'd4:    n = 4'd5;
			3'd5:    n = 4'd4;
			3'd6:    n = 4'd5;
			default: n = 4'd0;
		endcase
		return n;
	endfunction

endpackage
`default_nettype wire

FILE: design/btps_ifs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Buzzer tone pattern sequencer channels
// Request, tone result and configuration write channels.
// ----------------------------------------------------------------------------
interface btps_req_if;
	logic       valid;
	logic       ready;
	logic [1:0] req_type;
	logic [2:0] pattern_id;
	logic       mute_enable;

	modport source (output valid, req_type, pattern_id, mute_enable, input ready);
	modport sink   (input valid, req_type, pattern_id, mute_enable, output ready);
endinterface

interface btps_tone_if;
	logic        valid;
	logic        ready;
	logic [9:0]  tone_freq;
	logic [15:0] tone_duty;
	logic        playing;
	logic [3:0]  step_number;

	modport source (output valid, tone_freq, tone_duty, playing, step_number, input ready);
	modport sink   (input valid, tone_freq, tone_duty, playing, step_number, output ready);
endinterface

interface btps_cfg_if;
	logic       valid;
	logic       ready;
	logic [4:0] data;

	modport source (output valid, data, input ready);
	modport sink   (input valid, data, output ready);
endinterface
`default_nettype wire

FILE: design/btps_next.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Buzzer tone pattern sequencer next-state logic
// Applies one request to the player state and loads tone steps from the ROM.
// ----------------------------------------------------------------------------
module btps_next (
	input  btps_pkg::play_state_t cur,
	input  logic [1:0]            req_type,
	input  logic [2:0]            pattern_id,
	input  logic                  mute_enable,
	input  logic [4:0]            duty_res,
	output btps_pkg::play_state_t nxt
);
	import btps_pkg::*;

	play_state_t base;
	logic        load;
	step_t       rom;
	logic [4:0]  res_c;
	logic [15:0] full;
	logic [46:0] prod;
	logic [15:0] duty;

	// Request decode; a stop clears the play fields right here.
	always_comb begin
		base = cur;
		load = 1'b0;
		unique case (req_code_t'(req_type))
			REQ_TICK: begin
				if (cur.playing) begin
					if (cur.ms_left > 9'd1) begin
						base.ms_left = cur.ms_left - 9'd1;
					end else begin
						base.step = cur.step + 4'd1;
						if (base.step < pat_len(cur.pattern)) begin
							load = 1'b1;
						end else begin
							base.playing = 1'b0;
							base.pattern = '0;
							base.step    = '0;
							base.ms_left = '0;
							base.freq    = '0;
							base.duty    = '0;
						end
					end
				end
			end
			REQ_BEEP: begin
				base.pattern = '0;
				base.step    = '0;
				base.ms_left = '0;
				base.freq    = '0;
				base.duty    = '0;
				base.playing = 1'b0;
				if (pattern_id != PAT_INVALID) begin
					base.pattern = pattern_id;
					base.playing = 1'b1;
					load         = 1'b1;
				end
			end
			REQ_MUTE: begin
				base.muted = mute_enable;
				if (mute_enable) begin
					base.playing = 1'b0;
					base.pattern = '0;
					base.step    = '0;
					base.ms_left = '0;
					base.freq    = '0;
					base.duty    = '0;
				end
			end
			default: begin
			end
		endcase
	end

	assign rom = step_rom(base.pattern, base.step);

	// Full scale duty from the clamped resolution, then volume scaling.
	always_comb begin
		priority if (duty_res < RES_MIN) begin
			res_c = RES_MIN;
		end else if (duty_res > RES_MAX) begin
			res_c = RES_MAX;
		end else begin
			res_c = duty_res;
		end
	end

	assign full = 16'hFFFF >> (RES_MAX - res_c);
	assign prod = 47'(full) * 47'(rom.scale);

	always_comb begin
		duty = prod[DUTY_SHIFT +: 16];
		if (duty == 16'd0) begin
			duty = 16'd1;
		end
	end

	always_comb begin
		nxt = base;
		if (load) begin
			nxt.ms_left = rom.dur;
			if (base.muted || rom.freq == 10'd0 || rom.scale == 31'd0) begin
				nxt.freq = '0;
				nxt.duty = '0;
			end else begin
				nxt.freq = rom.freq;
				nxt.duty = duty;
			end
		end
	end

endmodule
`default_nettype wire

FILE: design/buzzer_tone_pattern_sequencer_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Buzzer tone pattern sequencer core
// Plays fixed tone patterns from a step ROM and reports the tone per request.
// ----------------------------------------------------------------------------
// Each request transaction (a millisecond tick, a beep request or a mute
// setting) produces exactly one tone transaction that shows the player state
// after the request: frequency, PWM duty, playing flag and step number. The
// block takes one request per clock cycle when the tone side keeps ready high;
// a request passes an input register, and the result is held in a registered
// output until the tone side takes it. The whole update, including the ROM
// lookup and the single 16 by 31 bit duty multiply, sits between those two
// registers, and the player state is updated in the same cycle, so the next
// request sees it right away. When the tone side stalls, the held result and
// the input register together absorb one more request before ready drops.
// The duty resolution register is written through the configuration channel,
// which is always ready; it should only be changed while no request is in
// flight. Values below 1 act as 1 and values above 16 act as 16.
// ----------------------------------------------------------------------------
module buzzer_tone_pattern_sequencer_core (
	input  logic           clk,
	input  logic           arst_n,
	btps_cfg_if.sink       cfg,
	btps_req_if.sink       req,
	btps_tone_if.source    tone
);
	import btps_pkg::*;

	logic        valid_s1;
	logic [1:0]  req_type_s1;
	logic [2:0]  pattern_id_s1;
	logic        mute_enable_s1;

	logic        out_valid_q;
	logic [9:0]  freq_q;
	logic [15:0] duty_q;
	logic        playing_q;
	logic [3:0]  step_q;

	logic [4:0]  duty_res_q;
	play_state_t state_q;
	play_state_t state_nxt;
	logic        advance;

	// The stage moves on whenever the output register is free or being drained.
	assign advance   = !out_valid_q || tone.ready;
	assign req.ready = !valid_s1 || advance;
	assign cfg.ready = 1'b1;

	btps_next u_next (
		.cur         (state_q),
		.req_type    (req_type_s1),
		.pattern_id  (pattern_id_s1),
		.mute_enable (mute_enable_s1),
		.duty_res    (duty_res_q),
		.nxt         (state_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			duty_res_q <= RES_RESET;
		end else if (cfg.valid && cfg.ready) begin
			duty_res_q <= cfg.data;
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.ready && req.valid) begin
			req_type_s1    <= req.req_type;
			pattern_id_s1  <= req.pattern_id;
			mute_enable_s1 <= req.mute_enable;
		end
	end

	// Player state and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= '0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
			if (valid_s1) begin
				state_q <= state_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			freq_q    <= state_nxt.freq;
			duty_q    <= state_nxt.duty;
			playing_q <= state_nxt.playing;
			step_q    <= state_nxt.step;
		end
	end

	assign tone.valid       = out_valid_q;
	assign tone.tone_freq   = freq_q;
	assign tone.tone_duty   = duty_q;
	assign tone.playing     = playing_q;
	assign tone.step_number = step_q;

	// An idle player holds no tone and sits at step zero.
	a_idle_clear: assert property (@(posedge clk) disable iff (!arst_n)
		!state_q.playing |-> (state_q.freq == 10'd0 && state_q.duty == 16'd0
			&& state_q.step == 4'd0))
		else $error("idle player holds a tone or a step");

	// A sounding tone always has a nonzero duty, a silent one has none.
	a_freq_duty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q.freq == 10'd0) == (state_q.duty == 16'd0))
		else $error("frequency and duty disagree on silence");

	// While muted nothing sounds.
	a_muted_silent: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.muted |-> state_q.freq == 10'd0)
		else $error("tone sounds while muted");

	// A request in the input stage reaches the output register once it moves.
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && advance) |=> out_valid_q)
		else $error("request lost between stages");

endmodule
`default_nettype wire

FILE: sim/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Buzzer tone pattern sequencer testbench
// Drives request transactions into the sequencer core, predicts the tone that
// each one must produce and checks every tone transaction field by field.
// A short table of directed requests comes first, then bursts of random
// requests run in several phases with different duty resolutions and
// different idle and stall patterns on the request and tone channels.
// ----------------------------------------------------------------------------
module testbench;
	import btps_pkg::*;

	// The unused request code, which the core must ignore.
	localparam logic [1:0] REQ_UNUSED = 2'd3;

	// Pattern ids.
	localparam logic [2:0] PAT_READY  = 3'd0;
	localparam logic [2:0] PAT_TARGET = 3'd1;
	localparam logic [2:0] PAT_ALARM  = 3'd2;
	localparam logic [2:0] PAT_POINT  = 3'd3;
	localparam logic [2:0] PAT_START  = 3'd4;
	localparam logic [2:0] PAT_ERROR  = 3'd5;
	localparam logic [2:0] PAT_STOP   = 3'd6;
	localparam int PAT_COUNT = 7;

	localparam int PHASE_REQUESTS = 400;
	localparam int PHASE_COUNT    = 5;
	localparam int SETTLE_CYCLES  = 4;
	localparam int WATCHDOG_LIMIT = 5000;  // cycles without any transaction

	typedef struct packed {
		logic [9:0]  freq;
		logic [15:0] duty;
		logic        playing;
		logic [3:0]  step;
	} tone_t;

	localparam tone_t SILENT = '0;

	// One row of the directed table. When typed is set, want holds the tone
	// read straight off the pattern table; otherwise the predictor decides.
	typedef struct packed {
		logic [1:0] kind;
		logic [2:0] pat;
		logic       mute;
		logic       typed;
		tone_t      want;
	} directed_row_t;

	// The directed table runs at the reset resolution of 8 bits, so full
	// scale is 255 and duty = 255 * volume / 100.
	localparam int DIRECTED_ROWS = 26;
	directed_row_t directed_rows [DIRECTED_ROWS] = '{
		'{REQ_TICK,   3'd0,        1'b0, 1'b1, SILENT},            // tick while idle
		'{REQ_UNUSED, 3'd5,        1'b1, 1'b1, SILENT},            // unused code, idle
		'{REQ_BEEP,   PAT_READY,   1'b0, 1'b1, '{10'd440, 16'd229, 1'b1, 4'd0}},
		'{REQ_TICK,   3'd0,        1'b0, 1'b0, SILENT},
		'{REQ_BEEP,   PAT_INVALID, 1'b0, 1'b1, SILENT},            // invalid id stops
		'{REQ_BEEP,   PAT_TARGET,  1'b0, 1'b1, '{10'd880, 16'd127, 1'b1, 4'd0}},
		'{REQ_BEEP,   PAT_ALARM,   1'b1, 1'b1, '{10'd800, 16'd255, 1'b1, 4'd0}},
		'{REQ_BEEP,   PAT_POINT,   1'b0, 1'b1, '{10'd600, 16'd255, 1'b1, 4'd0}},
		'{REQ_TICK,   3'd7,        1'b0, 1'b0, SILENT},
		'{REQ_TICK,   3'd0,        1'b1, 1'b0, SILENT},
		'{REQ_TICK,   3'd0,        1'b0, 1'b0, SILENT},
		'{REQ_TICK,   3'd0,        1'b0, 1'b0, SILENT},
		'{REQ_TICK,   3'd0,        1'b0, 1'b0, SILENT},            // advances to step 1
		'{REQ_BEEP,   PAT_START,   1'b0, 1'b1, '{10'd440, 16'd204, 1'b1, 4'd0}},
		'{REQ_BEEP,   PAT_ERROR,   1'b0, 1'b1, '{10'd120, 16'd178, 1'b1, 4'd0}},
		'{REQ_BEEP,   PAT_STOP,    1'b0, 1'b1, '{10'd660, 16'd255, 1'b1, 4'd0}},
		'{REQ_UNUSED, 3'd0,        1'b0, 1'b0, SILENT},            // unused code, playing
		'{REQ_MUTE,   3'd0,        1'b1, 1'b1, SILENT},            // mute on stops
		'{REQ_BEEP,   PAT_POINT,   1'b0, 1'b1, '{10'd0, 16'd0, 1'b1, 4'd0}},
		'{REQ_TICK,   3'd0,        1'b0, 1'b0, SILENT},
		'{REQ_TICK,   3'd0,        1'b0, 1'b0, SILENT},
		'{REQ_TICK,   3'd0,        1'b0, 1'b0, SILENT},
		'{REQ_TICK,   3'd0,        1'b0, 1'b0, SILENT},
		'{REQ_TICK,   3'd0,        1'b0, 1'b0, SILENT},            // silent step advance
		'{REQ_MUTE,   3'd0,        1'b0, 1'b0, SILENT},            // unmute keeps silence
		'{REQ_MUTE,   3'd0,        1'b0, 1'b0, SILENT}
	};

	// Tone step table, all patterns back to back, and where each pattern
	// starts and how many steps it has.
	int step_freq [35] = '{440, 0, 550, 0,
		880, 880, 880, 880, 0,
		800, 790, 0, 800, 790, 0, 800, 790, 0,
		600, 500, 0,
		440, 500, 580, 660, 0,
		120, 0, 100, 0,
		660, 580, 500, 440, 0};
	int step_ms [35] = '{100, 80, 120, 1,
		20, 400, 50, 30, 1,
		100, 100, 100, 100, 100, 100, 100, 100, 1,
		5, 25, 1,
		30, 30, 30, 30, 1,
		100, 50, 100, 1,
		30, 30, 30, 30, 1};
	int step_volume [35] = '{90, 0, 90, 0,
		50, 100, 60, 30, 0,
		100, 100, 0, 100, 100, 0, 100, 100, 0,
		100, 90, 0,
		80, 90, 100, 100, 0,
		70, 0, 70, 0,
		100, 100, 90, 80, 0};
	int pattern_first [PAT_COUNT] = '{0, 4, 9, 18, 21, 26, 30};
	int pattern_steps [PAT_COUNT] = '{4, 5, 9, 3, 5, 4, 5};

	logic clk;
	logic arst_n;

	btps_cfg_if  cfg_bus ();
	btps_req_if  req_bus ();
	btps_tone_if tone_bus ();

	buzzer_tone_pattern_sequencer_core uut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_bus),
		.req    (req_bus),
		.tone   (tone_bus)
	);

	// Player state as the predictor sees it.
	logic [4:0]  resolution;
	logic        player_on;
	logic        player_muted;
	logic [2:0]  player_pattern;
	logic [3:0]  player_step;
	logic [8:0]  player_ms;
	logic [9:0]  player_freq;
	logic [15:0] player_duty;

	// Tones that the core still owes us, oldest first.
	tone_t pending_tones [$];

	// What the request currently on the bus expects, set by the driver
	// together with the payload and read by the monitor on acceptance.
	logic  row_typed;
	tone_t row_want;

	int sender_idle_pct;
	int receiver_stall_pct;
	int error_count;
	int quiet_cycles;

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------

	task automatic stop_playback();
		player_on      = 1'b0;
		player_step    = '0;
		player_pattern = '0;
		player_ms      = '0;
		player_freq    = '0;
		player_duty    = '0;
	endtask

	// Loads the tone of the current step. A muted player, a zero frequency
	// or a zero volume all give silence; otherwise the duty is scaled from
	// full scale at the clamped resolution and never drops below 1.
	task automatic load_tone_step();
		int idx;
		int bits;
		int full_scale;
		int duty;
		idx = pattern_first[player_pattern] + player_step;
		player_ms = 9'(step_ms[idx]);
		if (player_muted || step_freq[idx] == 0 || step_volume[idx] == 0) begin
			player_freq = '0;
			player_duty = '0;
		end else begin
			bits = resolution;
			if (bits < 1)
				bits = 1;
			if (bits > 16)
				bits = 16;
			full_scale = (1 << bits) - 1;
			duty = (full_scale * step_volume[idx]) / 100;
			if (duty < 1)
				duty = 1;
			player_freq = 10'(step_freq[idx]);
			player_duty = 16'(duty);
		end
	endtask

	task automatic advance_player(input logic [1:0] kind, input logic [2:0] pat,
			input logic mute, output tone_t result);
		case (kind)
			REQ_TICK: begin
				if (player_on) begin
					if (player_ms > 1) begin
						player_ms = player_ms - 1'b1;
					end else begin
						player_step = player_step + 1'b1;
						if (player_step < pattern_steps[player_pattern])
							load_tone_step();
						else
							stop_playback();
					end
				end
			end
			REQ_BEEP: begin
				stop_playback();
				if (pat != PAT_INVALID) begin
					player_pattern = pat;
					player_step    = '0;
					player_on      = 1'b1;
					load_tone_step();
				end
			end
			REQ_MUTE: begin
				player_muted = mute;
				if (mute)
					stop_playback();
			end
			default: ;
		endcase
		result = '{player_freq, player_duty, player_on, player_step};
	endtask

	// ------------------------------------------------------------------
	// Clock, reset and the tone side's ready
	// ------------------------------------------------------------------

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// The tone side drops ready at random, at the falling edge, at the rate
	// that the current phase asks for.
	always @(negedge clk) begin
		tone_bus.ready = ($urandom_range(0, 99) >= receiver_stall_pct);
	end

	// ------------------------------------------------------------------
	// Monitor: every transaction is sampled at the rising edge. A request
	// transaction first runs through the predictor and queues its tone, then
	// a tone transaction is compared with the oldest tone in the queue. With
	// the core's latency the two never belong to the same request, but this
	// order stays correct even if they did.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		tone_t predicted;
		tone_t want;
		tone_t seen;
		if (arst_n) begin
			if (cfg_bus.valid && cfg_bus.ready)
				resolution = cfg_bus.data;
			if (req_bus.valid && req_bus.ready) begin
				advance_player(req_bus.req_type, req_bus.pattern_id, req_bus.mute_enable,
					predicted);
				pending_tones.push_back(row_typed ? row_want : predicted);
			end
			if (tone_bus.valid && tone_bus.ready) begin
				seen = '{tone_bus.tone_freq, tone_bus.tone_duty, tone_bus.playing,
					tone_bus.step_number};
				if (pending_tones.size() == 0) begin
					$display("%0t: tone transaction with none expected: freq %0d duty %0d playing %0d step %0d",
						$time, seen.freq, seen.duty, seen.playing, seen.step);
					error_count++;
				end else begin
					want = pending_tones.pop_front();
					if (seen.freq !== want.freq) begin
						$display("%0t: tone_freq expected %0d actual %0d",
							$time, want.freq, seen.freq);
						error_count++;
					end
					if (seen.duty !== want.duty) begin
						$display("%0t: tone_duty expected %0d actual %0d",
							$time, want.duty, seen.duty);
						error_count++;
					end
					if (seen.playing !== want.playing) begin
						$display("%0t: playing expected %0d actual %0d",
							$time, want.playing, seen.playing);
						error_count++;
					end
					if (seen.step !== want.step) begin
						$display("%0t: step_number expected %0d actual %0d",
							$time, want.step, seen.step);
						error_count++;
					end
				end
			end
		end
	end

	// The watchdog ends a run that has hung: it counts cycles in which no
	// transaction moves on any channel.
	always @(posedge clk) begin
		if (!arst_n || (req_bus.valid && req_bus.ready) || (tone_bus.valid && tone_bus.ready)
				|| (cfg_bus.valid && cfg_bus.ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------
	// Driver. Every task starts and ends at a falling edge.
	// ------------------------------------------------------------------

	// Offers one request transaction and holds it until it is accepted. The
	// sender goes idle first with the probability of the current phase.
	task automatic send_request(input logic [1:0] kind, input logic [2:0] pat,
			input logic mute, input logic typed, input tone_t want);
		while ($urandom_range(0, 99) < sender_idle_pct) begin
			req_bus.valid = 1'b0;
			@(negedge clk);
		end
		req_bus.req_type    = kind;
		req_bus.pattern_id  = pat;
		req_bus.mute_enable = mute;
		row_typed           = typed;
		row_want            = want;
		req_bus.valid       = 1'b1;
		do
			@(posedge clk);
		while (!req_bus.ready);
		@(negedge clk);
	endtask

	task automatic send_random(input logic [1:0] kind);
		send_request(kind, 3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)), 1'b0, SILENT);
	endtask

	// Lets every owed tone arrive, then waits out SETTLE_CYCLES for the pipeline.
	task automatic drain_tones();
		req_bus.valid = 1'b0;
		while (pending_tones.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Writes the duty resolution once the core has gone quiet.
	task automatic write_resolution(input logic [4:0] value);
		drain_tones();
		cfg_bus.data  = value;
		cfg_bus.valid = 1'b1;
		do
			@(posedge clk);
		while (!cfg_bus.ready);
		@(negedge clk);
		cfg_bus.valid = 1'b0;
	endtask

	// Random requests in bursts: a beep of any id, then a run of ticks that
	// is either short or long enough to play most patterns to the end. A few
	// items in each run are noise: mute changes, unused codes and new beeps.
	task automatic run_bursts(input int budget);
		int sent;
		int run_length;
		int roll;
		sent = 0;
		while (sent < budget) begin
			send_random(REQ_BEEP);
			sent++;
			if ($urandom_range(0, 1))
				run_length = $urandom_range(1, 40);
			else
				run_length = $urandom_range(100, 900);
			for (int k = 0; k < run_length && sent < budget; k++) begin
				roll = $urandom_range(0, 99);
				if (roll < 2)
					send_request(REQ_MUTE, 3'($urandom_range(0, 7)),
						1'($urandom_range(0, 3) == 0), 1'b0, SILENT);
				else if (roll < 3)
					send_random(REQ_UNUSED);
				else if (roll < 4)
					send_random(REQ_BEEP);
				else
					send_random(REQ_TICK);
				sent++;
			end
		end
	endtask

	// ------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------
	initial begin
		logic [4:0] phase_resolution [PHASE_COUNT];
		directed_row_t row;

		// Every input is known from time zero.
		clk                 = 1'b0;
		arst_n              = 1'b0;
		req_bus.valid       = 1'b0;
		req_bus.req_type    = REQ_TICK;
		req_bus.pattern_id  = PAT_READY;
		req_bus.mute_enable = 1'b0;
		cfg_bus.valid       = 1'b0;
		cfg_bus.data        = RES_RESET;
		tone_bus.ready      = 1'b0;
		row_typed           = 1'b0;
		row_want            = SILENT;
		sender_idle_pct     = 0;
		receiver_stall_pct  = 0;
		error_count         = 0;
		quiet_cycles        = 0;

		resolution     = RES_RESET;
		player_muted   = 1'b0;
		stop_playback();

		// Resolutions by phase: both ends of the range, both out of range
		// values that must clamp, and one random value in between.
		phase_resolution = '{RES_MAX, RES_MIN, 5'd31, 5'd0, 5'($urandom_range(2, 15))};

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part, at the reset resolution and without idling.
		for (int i = 0; i < DIRECTED_ROWS; i++) begin
			row = directed_rows[i];
			send_request(row.kind, row.pat, row.mute, row.typed, row.want);
		end

		// Random part. The idle mode rotates through no idling, an idle
		// sender, a stalling receiver and both idling a little.
		for (int phase = 0; phase < PHASE_COUNT; phase++) begin
			write_resolution(phase_resolution[phase]);
			case (phase % 4)
				0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
				1: begin sender_idle_pct = 58; receiver_stall_pct = 0;  end
				2: begin sender_idle_pct = 0;  receiver_stall_pct = 58; end
				default: begin sender_idle_pct = 9; receiver_stall_pct = 9; end
			endcase
			run_bursts(PHASE_REQUESTS);
		end

		drain_tones();
		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
